>>> design/byte_substring_search_macros.svh
// assertion macros for the byte substring search block
`ifndef BYTE_SUBSTRING_SEARCH_MACROS_SVH
`define BYTE_SUBSTRING_SEARCH_MACROS_SVH

// same-cycle implication, disabled while in reset
`define BSS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("byte_substring_search assertion failed");

// next-cycle implication, disabled while in reset
`define BSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("byte_substring_search assertion failed");

`endif

>>> design/bss_pkg.sv
// types and constants of the byte substring search block
package bss_pkg;

   localparam int PATTERN_MAX_DEF = 64;
   localparam int BUFFER_MAX_DEF  = 4096;
   localparam int OFFSET_W        = 12;
   localparam int ALPHABET        = 256;

   localparam logic [1:0] CMD_PATTERN = 2'd0;
   localparam logic [1:0] CMD_BUFFER  = 2'd1;
   localparam logic [1:0] CMD_SEARCH  = 2'd2;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] data_byte;
   } req_word_type;

   typedef struct packed {
      logic                found;
      logic [OFFSET_W-1:0] match_offset;
      logic                overflow;
   } rsp_word_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic found;
   } eng_status_type;

endpackage

>>> design/byte_substring_search.sv
// top level of the byte substring search block
//
//  channel  direction  handshake              word
//  req      in         req_valid/req_ready    req_word (cmd, data_byte)
//  rsp      out        rsp_valid/rsp_ready    rsp_word (found, match_offset, overflow)
//
// appends are accepted one word per cycle; a search holds req_ready low while it runs
// search: skip table build, then byte compares and window shifts, paced by the
// single read port of the buffer ram under the compare sequencer
// reset is synchronous and clears lengths, overflow flag, sequencer and rsp_valid
// a result waiting on rsp_ready stalls only the next search, appends still flow
`include "byte_substring_search_macros.svh"

module byte_substring_search #(
   parameter int PATTERN_MAX = bss_pkg::PATTERN_MAX_DEF,
   parameter int BUFFER_MAX  = bss_pkg::BUFFER_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bss_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bss_pkg::rsp_word_type rsp_word
);

   import bss_pkg::*;

   localparam int PLW = $clog2(PATTERN_MAX + 1);
   localparam int PAW = $clog2(PATTERN_MAX);
   localparam int BLW = $clog2(BUFFER_MAX + 1);
   localparam int BAW = $clog2(BUFFER_MAX);
   localparam int OW  = (BLW > OFFSET_W) ? BLW : OFFSET_W;

   logic [PLW-1:0] plen_ff, plen_in;
   logic [BLW-1:0] blen_ff, blen_in;
   logic           dropped_ff, dropped_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_word_type   rsp_word_ff, rsp_word_in;

   logic           req_fire;
   logic           pat_wr_en;
   logic           buf_wr_en;
   logic           search_start;
   logic [PAW-1:0] pat_rd_addr;
   logic [7:0]     pat_rd_data;
   logic [BAW-1:0] buf_rd_addr;
   logic [7:0]     buf_rd_data;
   eng_status_type eng_status;
   logic [BLW-1:0] match_pos;
   logic [OW-1:0]  pos_ext;

   // a search only starts once the result register is free
   assign req_ready = !eng_status.busy &&
                      ((req_word.cmd != CMD_SEARCH) || !rsp_valid_ff || rsp_ready);
   assign req_fire     = req_valid && req_ready;
   assign pat_wr_en    = req_fire && (req_word.cmd == CMD_PATTERN) &&
                         (plen_ff < PLW'(PATTERN_MAX));
   assign buf_wr_en    = req_fire && (req_word.cmd == CMD_BUFFER) &&
                         (blen_ff < BLW'(BUFFER_MAX));
   assign search_start = req_fire && (req_word.cmd == CMD_SEARCH);

   bss_ram #(
      .WIDTH(8),
      .DEPTH(PATTERN_MAX)
   ) u_pattern_ram (
      .clock   (clock),
      .wr_en   (pat_wr_en),
      .wr_addr (plen_ff[PAW-1:0]),
      .wr_data (req_word.data_byte),
      .rd_addr (pat_rd_addr),
      .rd_data (pat_rd_data)
   );

   bss_ram #(
      .WIDTH(8),
      .DEPTH(BUFFER_MAX)
   ) u_buffer_ram (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (blen_ff[BAW-1:0]),
      .wr_data (req_word.data_byte),
      .rd_addr (buf_rd_addr),
      .rd_data (buf_rd_data)
   );

   bss_engine #(
      .PATTERN_MAX(PATTERN_MAX),
      .BUFFER_MAX (BUFFER_MAX)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (search_start),
      .plen        (plen_ff),
      .blen        (blen_ff),
      .pat_rd_addr (pat_rd_addr),
      .pat_rd_data (pat_rd_data),
      .buf_rd_addr (buf_rd_addr),
      .buf_rd_data (buf_rd_data),
      .status      (eng_status),
      .match_pos   (match_pos)
   );

   assign pos_ext = OW'(match_pos);

   always_comb begin
      plen_in      = plen_ff;
      blen_in      = blen_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      if (pat_wr_en) begin
         plen_in = plen_ff + PLW'(1);
      end
      if (buf_wr_en) begin
         blen_in = blen_ff + BLW'(1);
      end
      if (req_fire && !pat_wr_en && !buf_wr_en &&
          ((req_word.cmd == CMD_PATTERN) || (req_word.cmd == CMD_BUFFER))) begin
         dropped_in = 1'b1;
      end
      if (eng_status.done) begin
         rsp_valid_in             = 1'b1;
         rsp_word_in.found        = eng_status.found;
         rsp_word_in.match_offset = pos_ext[OFFSET_W-1:0];
         rsp_word_in.overflow     = dropped_ff;
         plen_in                  = '0;
         blen_in                  = '0;
         dropped_in               = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff      <= '0;
         blen_ff      <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         plen_ff      <= plen_in;
         blen_ff      <= blen_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `BSS_ASSERT_NEXT(a_search_starts_engine, clock, reset, search_start, eng_status.busy)
   `BSS_ASSERT_NOW(a_done_slot_free, clock, reset, eng_status.done, !rsp_valid_ff)
   `BSS_ASSERT_NOW(a_no_accept_busy, clock, reset, eng_status.busy, !req_ready)
   `BSS_ASSERT_NOW(a_miss_zero_offset, clock, reset, rsp_valid && !rsp_word.found, rsp_word.match_offset == '0)

endmodule

>>> design/bss_ram.sv
// generic single-port-write, registered-read RAM
module bss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/bss_engine.sv
// horspool search sequencer: skip table build and window compare loop
module bss_engine #(
   parameter int PATTERN_MAX = bss_pkg::PATTERN_MAX_DEF,
   parameter int BUFFER_MAX  = bss_pkg::BUFFER_MAX_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [$clog2(PATTERN_MAX+1)-1:0]   plen,
   input  logic [$clog2(BUFFER_MAX+1)-1:0]    blen,
   output logic [$clog2(PATTERN_MAX)-1:0]     pat_rd_addr,
   input  logic [7:0]                         pat_rd_data,
   output logic [$clog2(BUFFER_MAX)-1:0]      buf_rd_addr,
   input  logic [7:0]                         buf_rd_data,
   output bss_pkg::eng_status_type            status,
   output logic [$clog2(BUFFER_MAX+1)-1:0]    match_pos
);

   import bss_pkg::*;

   localparam int PLW = $clog2(PATTERN_MAX + 1);
   localparam int PAW = $clog2(PATTERN_MAX);
   localparam int BLW = $clog2(BUFFER_MAX + 1);
   localparam int BAW = $clog2(BUFFER_MAX);
   localparam int SW  = $clog2(BUFFER_MAX + 2 * PATTERN_MAX + 1);
   localparam int AAW = $clog2(ALPHABET);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_BRD   = 3'd2;
   localparam logic [2:0] S_BWR   = 3'd3;
   localparam logic [2:0] S_CRD   = 3'd4;
   localparam logic [2:0] S_CMP   = 3'd5;
   localparam logic [2:0] S_TRD   = 3'd6;
   localparam logic [2:0] S_ADV   = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [PAW-1:0]      k_ff, k_in;
   logic [PAW-1:0]      i_ff, i_in;
   logic [BLW-1:0]      pos_ff, pos_in;
   logic                found_ff, found_in;
   logic                done_ff, done_in;
   logic [ALPHABET-1:0] valid_ff, valid_in;
   logic                vhit_ff, vhit_in;
   logic                skrd_ff, skrd_in;

   logic [PLW-1:0] last;
   logic [PAW-1:0] last_idx;
   logic           skip_wr_en;
   logic [AAW-1:0] skip_wr_addr;
   logic [PLW-1:0] skip_wr_data;
   logic [PLW-1:0] skip_rd_data;
   logic [PLW-1:0] skip_val;
   logic [SW-1:0]  new_pos;
   logic [SW-1:0]  new_end;
   logic [BLW-1:0] addr_cmp;
   logic [BLW-1:0] addr_tail;

   assign last      = plen - PLW'(1);
   assign last_idx  = last[PAW-1:0];
   assign addr_cmp  = pos_ff + BLW'(i_ff);
   assign addr_tail = pos_ff + BLW'(last_idx);
   assign skip_val  = vhit_ff ? skip_rd_data : plen;
   assign new_pos   = SW'(pos_ff) + SW'(skip_val);
   assign new_end   = new_pos + SW'(plen);

   // skip table: entries without a valid bit read as the pattern length
   bss_ram #(
      .WIDTH(PLW),
      .DEPTH(ALPHABET)
   ) u_skip_ram (
      .clock   (clock),
      .wr_en   (skip_wr_en),
      .wr_addr (skip_wr_addr),
      .wr_data (skip_wr_data),
      .rd_addr (buf_rd_data),
      .rd_data (skip_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      pos_in       = pos_ff;
      found_in     = found_ff;
      done_in      = 1'b0;
      valid_in     = valid_ff;
      vhit_in      = vhit_ff;
      skrd_in      = 1'b0;
      skip_wr_en   = 1'b0;
      skip_wr_addr = pat_rd_data;
      skip_wr_data = last - PLW'(k_ff);
      pat_rd_addr  = (state_ff == S_BRD) ? k_ff : i_ff;
      buf_rd_addr  = (state_ff == S_TRD) ? addr_tail[BAW-1:0] : addr_cmp[BAW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (done_ff) begin
               done_in = 1'b0;
            end else if (start) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            pos_in   = '0;
            k_in     = '0;
            i_in     = last_idx;
            valid_in = '0;
            if (plen == '0) begin
               found_in = 1'b1;
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else if (SW'(plen) > SW'(blen)) begin
               found_in = 1'b0;
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else if (last == '0) begin
               state_in = S_CRD;
            end else begin
               state_in = S_BRD;
            end
         end
         S_BRD: begin
            state_in = S_BWR;
         end
         S_BWR: begin
            skip_wr_en            = 1'b1;
            valid_in[pat_rd_data] = 1'b1;
            k_in                  = k_ff + PAW'(1);
            if (PLW'(k_ff) + PLW'(1) == last) begin
               state_in = S_CRD;
            end else begin
               state_in = S_BRD;
            end
         end
         S_CRD: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (buf_rd_data == pat_rd_data) begin
               if (i_ff == '0) begin
                  found_in = 1'b1;
                  done_in  = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_ff - PAW'(1);
                  state_in = S_CRD;
               end
            end else begin
               state_in = S_TRD;
            end
         end
         S_TRD: begin
            // byte under the window's last position comes back next cycle
            state_in = S_ADV;
            skrd_in  = 1'b1;
         end
         S_ADV: begin
            if (skrd_ff) begin
               // buffer byte is on the read data, look it up in the skip table
               vhit_in = valid_ff[buf_rd_data];
            end else begin
               i_in = last_idx;
               if (new_end > SW'(blen)) begin
                  found_in = 1'b0;
                  pos_in   = '0;
                  done_in  = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  pos_in   = new_pos[BLW-1:0];
                  state_in = S_CRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
         skrd_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         skrd_ff  <= skrd_in;
      end
      k_ff     <= k_in;
      i_ff     <= i_in;
      pos_ff   <= pos_in;
      found_ff <= found_in;
      valid_ff <= valid_in;
      vhit_ff  <= vhit_in;
   end

   assign status.busy  = (state_ff != S_IDLE) || done_ff;
   assign status.done  = done_ff;
   assign status.found = found_ff;
   assign match_pos    = found_ff ? pos_ff : '0;

endmodule
